// ===== src/est_pkg.sv =====
// Shared types and constants for the event sequence trigger matcher.
package est_pkg;

    localparam int HIST_DEPTH_DFLT  = 8;
    localparam int TBL_ENTRIES_DFLT = 16;

    localparam int EVT_W       = 9;
    localparam int CODE_W      = 8;
    localparam int OP_W        = 2;
    localparam int IN_ENTRY_W  = 4;
    localparam int IN_POS_W    = 3;
    localparam int IN_LEN_W    = 4;
    localparam int OUT_ENTRY_W = 4;
    localparam int CFG_W       = 5;

    localparam logic [OP_W-1:0] OP_EVENT = 2'd0;
    localparam logic [OP_W-1:0] OP_ELEM  = 2'd1;
    localparam logic [OP_W-1:0] OP_LEN   = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [CODE_W-1:0]     event_code;
        logic                  event_up;
        logic [IN_ENTRY_W-1:0] entry;
        logic [IN_POS_W-1:0]   position;
        logic [IN_LEN_W-1:0]   length;
    } t_in_item;

    typedef struct packed {
        logic [OUT_ENTRY_W-1:0] match_entry;
        logic                   last;
    } t_out_item;

endpackage

// ===== src/est_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module est_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/est_match.sv =====
// Compare unit: tests one pattern row against the newest events of the history.
module est_match import est_pkg::*; #(
    parameter int HISTORY_DEPTH = HIST_DEPTH_DFLT,
    localparam int LW = $clog2(HISTORY_DEPTH + 1),
    localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
    input  logic [EVT_W-1:0]               i_hist [HISTORY_DEPTH],
    input  logic [HISTORY_DEPTH*EVT_W-1:0] i_row,
    input  logic [LW-1:0]                  i_len,
    output logic                           o_hit
);

    logic [HISTORY_DEPTH-1:0] lane_ok;

    // pattern element p (oldest first) lines up with history slot len-1-p
    always_comb begin
        logic [LW-1:0] h;
        for (int p = 0; p < HISTORY_DEPTH; p++) begin
            h = i_len - LW'(p + 1);
            if (p >= int'(i_len)) begin
                lane_ok[p] = 1'b1;
            end else begin
                lane_ok[p] = (i_row[p*EVT_W +: EVT_W] == i_hist[h[PW-1:0]]);
            end
        end
    end

    assign o_hit = &lane_ok;

endmodule

// ===== src/event_sequence_trigger_matcher.sv =====
// An event (op 0) holds the input while the sequencer scans min(entries_in_use, TABLE_ENTRIES)
// table entries, one table entry per cycle through the pattern RAM read port and the compare unit
// while the output register is not stalled. A pattern element write is a read-modify-write
// of the pattern row (read in S_IDLE, write in S_PWR); length writes and unused ops take only S_IDLE.
// Reset (i_rst_n low, synchronous) clears history, lengths, register and control;
// the pattern RAM is not cleared and holds undefined data until written.
module event_sequence_trigger_matcher import est_pkg::*; #(
    parameter int HISTORY_DEPTH = HIST_DEPTH_DFLT,
    parameter int TABLE_ENTRIES = TBL_ENTRIES_DFLT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int LW    = $clog2(HISTORY_DEPTH + 1);
    localparam int PW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int EW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int TW    = $clog2(TABLE_ENTRIES + 1);
    localparam int ROW_W = HISTORY_DEPTH * EVT_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PWR   = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]       r_state,    n_state;
    logic [TW-1:0]    r_limit,    n_limit;
    logic [TW-1:0]    r_rd_idx,   n_rd_idx;
    logic             r_cmp_vld,  n_cmp_vld;
    logic [EW-1:0]    r_cmp_idx,  n_cmp_idx;
    logic             r_hold_vld, n_hold_vld;
    logic [EW-1:0]    r_hold_idx, n_hold_idx;
    logic [EW-1:0]    r_ent,      n_ent;
    logic [PW-1:0]    r_pos,      n_pos;
    logic [EVT_W-1:0] r_evt,      n_evt;
    logic [CFG_W-1:0] r_eiu;
    logic             r_out_vld;
    t_out_item        r_out;

    logic [EVT_W-1:0] r_hist [HISTORY_DEPTH];
    logic [LW-1:0]    r_len  [TABLE_ENTRIES];

    logic             accept;
    logic             out_free;
    logic             ent_ok;
    logic             pos_ok;
    logic [EVT_W-1:0] in_evt;
    logic [TW-1:0]    lim;
    logic [LW-1:0]    len_sat;

    logic             ram_re;
    logic             ram_we;
    logic [EW-1:0]    ram_raddr;
    logic [ROW_W-1:0] ram_rdata;
    logic [ROW_W-1:0] wr_row;
    logic             hit;
    logic             push;
    logic             push_last;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_vld || i_out_ready;
    assign in_evt     = {i_in.event_up, i_in.event_code};
    assign ent_ok     = int'(i_in.entry) < TABLE_ENTRIES;
    assign pos_ok     = int'(i_in.position) < HISTORY_DEPTH;
    assign lim        = (int'(r_eiu) > TABLE_ENTRIES) ? TW'(TABLE_ENTRIES) : TW'(r_eiu);
    assign len_sat    = (int'(i_in.length) > HISTORY_DEPTH) ? LW'(HISTORY_DEPTH)
                                                            : LW'(i_in.length);

    // element write merges the new event into the row read the cycle before
    always_comb begin
        for (int p = 0; p < HISTORY_DEPTH; p++) begin
            wr_row[p*EVT_W +: EVT_W] = (PW'(p) == r_pos) ? r_evt
                                                         : ram_rdata[p*EVT_W +: EVT_W];
        end
    end

    est_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ent),
        .i_wdata (wr_row),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    est_match #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_match (
        .i_hist (r_hist),
        .i_row  (ram_rdata),
        .i_len  (r_len[r_cmp_idx]),
        .o_hit  (hit)
    );

    // sequencer; a match is held back one step so the final one can carry last
    always_comb begin
        n_state    = r_state;
        n_limit    = r_limit;
        n_rd_idx   = r_rd_idx;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_idx  = r_cmp_idx;
        n_hold_vld = r_hold_vld;
        n_hold_idx = r_hold_idx;
        n_ent      = r_ent;
        n_pos      = r_pos;
        n_evt      = r_evt;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        ram_raddr  = r_rd_idx[EW-1:0];
        push       = 1'b0;
        push_last  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.op == OP_EVENT) begin
                        n_limit    = lim;
                        n_rd_idx   = '0;
                        n_cmp_vld  = 1'b0;
                        n_hold_vld = 1'b0;
                        n_state    = S_SCAN;
                    end else if (i_in.op == OP_ELEM && ent_ok && pos_ok) begin
                        ram_re    = 1'b1;
                        ram_raddr = EW'(i_in.entry);
                        n_ent     = EW'(i_in.entry);
                        n_pos     = PW'(i_in.position);
                        n_evt     = in_evt;
                        n_state   = S_PWR;
                    end
                end
            end
            S_PWR: begin
                ram_we  = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (out_free) begin
                    if (r_cmp_vld && hit) begin
                        push       = r_hold_vld;
                        n_hold_vld = 1'b1;
                        n_hold_idx = r_cmp_idx;
                    end
                    if (r_rd_idx < r_limit) begin
                        ram_re    = 1'b1;
                        n_rd_idx  = r_rd_idx + TW'(1);
                        n_cmp_vld = 1'b1;
                        n_cmp_idx = r_rd_idx[EW-1:0];
                    end else begin
                        n_cmp_vld = 1'b0;
                        n_state   = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_hold_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    push       = 1'b1;
                    push_last  = 1'b1;
                    n_hold_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_limit    <= '0;
            r_rd_idx   <= '0;
            r_cmp_vld  <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_eiu      <= '0;
        end else begin
            r_state    <= n_state;
            r_limit    <= n_limit;
            r_rd_idx   <= n_rd_idx;
            r_cmp_vld  <= n_cmp_vld;
            r_hold_vld <= n_hold_vld;
            if (push) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_we) begin
                r_eiu <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= n_cmp_idx;
        r_hold_idx <= n_hold_idx;
        r_ent      <= n_ent;
        r_pos      <= n_pos;
        r_evt      <= n_evt;
        if (push) begin
            r_out.match_entry <= OUT_ENTRY_W'(r_hold_idx);
            r_out.last        <= push_last;
        end
    end

    // history and pattern lengths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
            for (int e = 0; e < TABLE_ENTRIES; e++) begin
                r_len[e] <= '0;
            end
        end else if (accept) begin
            if (i_in.op == OP_EVENT) begin
                for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
                    r_hist[i] <= r_hist[i-1];
                end
                r_hist[0] <= in_evt;
            end else if (i_in.op == OP_LEN && ent_ok) begin
                r_len[EW'(i_in.entry)] <= len_sat;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    a_hold_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_vld |-> (r_state == S_SCAN || r_state == S_FLUSH))
        else $error("held match outside a scan");

    a_rd_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_rd_idx <= r_limit))
        else $error("scan index past entry limit");

    a_push_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (TW'(r_hold_idx) < r_limit))
        else $error("reported entry outside entries in use");

    a_last_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && push_last) |=> (r_state == S_IDLE))
        else $error("sequencer busy after final result");

endmodule

// ===== test/est_match_checker.sv =====
// Result checker for the event sequence trigger matcher: watches transfers, predicts, compares.
module est_match_checker import est_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  t_in_item         i_in,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  t_out_item        i_out,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int DEPTH   = HIST_DEPTH_DFLT;
    localparam int ENTRIES = TBL_ENTRIES_DFLT;

    logic [EVT_W-1:0]    history [DEPTH];
    logic [EVT_W-1:0]    pat_elem [ENTRIES][DEPTH];
    logic [IN_LEN_W-1:0] pat_len [ENTRIES];
    logic [CFG_W-1:0]    entries_on;
    t_out_item           expected_matches [$];
    int                  fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        foreach (pat_elem[e, p]) pat_elem[e][p] = '0;
    end

    task automatic report_mismatch(input string msg);
        // print the first few only, keep counting the rest
        if (fails < 50) $display("%0t checker: %s", $time, msg);
        fails++;
    endtask

    function automatic bit entry_hit(input int e);
        int  n;
        bit  hit;
        n   = pat_len[e];
        hit = 1'b1;
        // pattern is oldest first, history[0] is the newest event
        for (int p = 0; p < n; p++)
            if (pat_elem[e][p] != history[n-1-p]) hit = 1'b0;
        return hit;
    endfunction

    task automatic take_event(input logic [EVT_W-1:0] evt);
        int        limit;
        int        hits [$];
        t_out_item res;
        for (int i = DEPTH - 1; i > 0; i--) history[i] = history[i-1];
        history[0] = evt;
        limit = (entries_on > ENTRIES) ? ENTRIES : int'(entries_on);
        for (int e = 0; e < limit; e++)
            if (entry_hit(e)) hits = {hits, e};
        foreach (hits[i]) begin
            res.match_entry = hits[i][OUT_ENTRY_W-1:0];
            res.last        = (i == hits.size() - 1);
            expected_matches = {expected_matches, res};
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            foreach (history[i]) history[i] = '0;
            foreach (pat_len[e]) pat_len[e] = '0;
            entries_on = '0;
            expected_matches.delete();
        end else begin
            if (i_cfg_we) entries_on = i_cfg_data;
            if (i_in_valid && i_in_ready) begin
                case (i_in.op)
                    OP_EVENT: take_event({i_in.event_up, i_in.event_code});
                    OP_ELEM:  pat_elem[i_in.entry][i_in.position] =
                                  {i_in.event_up, i_in.event_code};
                    OP_LEN:   pat_len[i_in.entry] = (i_in.length > DEPTH) ?
                                  IN_LEN_W'(DEPTH) : i_in.length;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_matches.size() == 0) begin
                    report_mismatch($sformatf("unexpected result entry %0d last %0b",
                                              i_out.match_entry, i_out.last));
                end else begin
                    want = expected_matches.pop_front();
                    if (i_out.match_entry !== want.match_entry || i_out.last !== want.last)
                        report_mismatch($sformatf(
                            "result entry %0d last %0b, want entry %0d last %0b",
                            i_out.match_entry, i_out.last, want.match_entry, want.last));
                end
            end
        end
        o_pending    <= expected_matches.size();
        o_fail_count <= fails;
    end

endmodule

// ===== test/tb_top.sv =====
// Top of the matcher testbench: clock, reset, stimulus, output stalls and verdict.
module tb_top;
    import est_pkg::*;

    localparam int DEPTH         = HIST_DEPTH_DFLT;
    localparam int ENTRIES       = TBL_ENTRIES_DFLT;
    localparam int ITEM_TARGET   = 370;
    localparam int SETTLE_CYCLES = ENTRIES + 8;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    t_in_item         in_item  = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out_item        out_item;
    logic             cfg_we   = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;

    int          fail_count;
    int          pending_count;
    int unsigned cyc        = 0;
    int          stall_left = 0;
    int          items_sent = 0;
    int          entries_now = 0;

    // what has been loaded into the pattern table, for shaping the event stream
    logic [EVT_W-1:0] shadow_elem [ENTRIES][DEPTH];
    logic [DEPTH-1:0] elem_known [ENTRIES];
    int               shadow_len [ENTRIES];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    event_sequence_trigger_matcher u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    est_match_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // stretches with no idling on either side
    function automatic bit calm();
        return (cyc % 700) < 160;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ready  <= 1'b1;
            stall_left <= calm() ? 0 : pick_gap();
        end
    end

    function automatic t_in_item rand_fields();
        t_in_item it;
        it.op         = OP_W'($urandom_range(0, 3));
        it.event_code = CODE_W'($urandom_range(0, 255));
        it.event_up   = 1'($urandom_range(0, 1));
        it.entry      = IN_ENTRY_W'($urandom_range(0, 15));
        it.position   = IN_POS_W'($urandom_range(0, 7));
        it.length     = IN_LEN_W'($urandom_range(0, 15));
        return it;
    endfunction

    // small code alphabet most of the time so that replays and overlaps hit
    function automatic logic [EVT_W-1:0] rand_evt();
        logic [CODE_W-1:0] code;
        code = ($urandom_range(0, 9) < 8) ? CODE_W'($urandom_range(0, 3))
                                          : CODE_W'($urandom_range(0, 255));
        return {1'($urandom_range(0, 1)), code};
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = calm() ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (it.op != OP_UNUSED) items_sent++;
    endtask

    task automatic send_event(input logic [EVT_W-1:0] evt);
        t_in_item it;
        it = rand_fields();
        it.op = OP_EVENT;
        {it.event_up, it.event_code} = evt;
        send_item(it);
    endtask

    task automatic send_noise();
        t_in_item it;
        it = rand_fields();
        it.op = OP_UNUSED;
        send_item(it);
    endtask

    task automatic write_elem(input int e, input int p, input logic [EVT_W-1:0] evt);
        t_in_item it;
        it = rand_fields();
        it.op       = OP_ELEM;
        it.entry    = e[IN_ENTRY_W-1:0];
        it.position = p[IN_POS_W-1:0];
        {it.event_up, it.event_code} = evt;
        send_item(it);
        shadow_elem[e][p] = evt;
        elem_known[e][p]  = 1'b1;
    endtask

    // elements under the new length are loaded first, so no blank element is ever compared
    task automatic write_len(input int e, input int len);
        t_in_item it;
        int       used;
        used = (len > DEPTH) ? DEPTH : len;
        for (int p = 0; p < used; p++)
            if (!elem_known[e][p]) write_elem(e, p, rand_evt());
        it = rand_fields();
        it.op     = OP_LEN;
        it.entry  = e[IN_ENTRY_W-1:0];
        it.length = len[IN_LEN_W-1:0];
        send_item(it);
        shadow_len[e] = used;
    endtask

    task automatic new_pattern(input int e);
        int len;
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, DEPTH) : $urandom_range(9, 15);
        for (int p = 0; p < ((len > DEPTH) ? DEPTH : len); p++) write_elem(e, p, rand_evt());
        write_len(e, len);
    endtask

    task automatic play_pattern(input int e);
        for (int p = 0; p < shadow_len[e]; p++) send_event(shadow_elem[e][p]);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        // an event with no match may still be scanning the table
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_entries(input int v);
        settle();
        cfg_data <= v[CFG_W-1:0];
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        entries_now = (v > ENTRIES) ? ENTRIES : v;
    endtask

    function automatic int pick_entry();
        if (entries_now > 0 && $urandom_range(0, 3) != 0)
            return $urandom_range(0, entries_now - 1);
        return $urandom_range(0, ENTRIES - 1);
    endfunction

    initial begin
        int cfg_plan [8] = '{16, 3, 31, 1, 0, 9, 17, 12};
        int phase;
        int r;
        t_in_item it;
        foreach (elem_known[e]) begin
            elem_known[e] = '0;
            shadow_len[e] = 0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // over-range count: every zero-length entry matches the reset history
        set_entries(31);
        send_event('0);
        it = '1;
        send_item(it);
        write_elem(15, 0, 9'h000);
        write_elem(15, 1, 9'h1FF);
        write_elem(15, 2, 9'h0AA);
        write_elem(15, 3, 9'h155);
        write_elem(15, 4, 9'h001);
        write_elem(15, 5, 9'h180);
        write_elem(15, 6, 9'h0FF);
        write_elem(15, 7, 9'h100);
        write_len(15, 15);
        play_pattern(15);
        // no entries in use: nothing comes back
        set_entries(0);
        send_event(9'h1FF);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            set_entries(phase < 8 ? cfg_plan[phase] : $urandom_range(0, 31));
            repeat ($urandom_range(1, 4)) new_pattern(pick_entry());
            repeat (25) begin
                r = $urandom_range(0, 99);
                if (r < 45 && entries_now > 0)
                    play_pattern($urandom_range(0, entries_now - 1));
                else if (r < 75)
                    send_event(rand_evt());
                else if (r < 85)
                    send_event(EVT_W'($urandom_range(0, 511)));
                else if (r < 90)
                    send_noise();
                else if (r < 96)
                    write_elem(pick_entry(), $urandom_range(0, DEPTH - 1), rand_evt());
                else
                    write_len(pick_entry(), $urandom_range(0, 15));
            end
            phase++;
        end

        settle();
        if (fail_count == 0 && pending_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #25_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
